// ----- rtl/assert_macros.svh -----
// Assertion macros used by the relay bank controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/grip_pkg.sv -----
// Shared constants, types and helpers of the relay bank driver.
package grip_pkg;

    // Bank geometry
    localparam int NUM_RELAYS = 8;
    localparam int GROUP_BITS = 3;
    localparam int IDX_W      = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;

    // Field and register widths
    localparam int MAP_W      = 24;
    localparam int GMAP_W     = NUM_RELAYS * GROUP_BITS;
    localparam int EL_W       = 16;
    localparam int KIND_W     = 3;
    localparam int RELAY_W    = 8;
    localparam int STATES_W   = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int IN_TDATA_W = 8;
    localparam int IN_TUSER_W = 3;
    localparam int OUT_TDATA_W = 16;

    localparam logic [EL_W-1:0] PULSE_WIDTH_RST = 16'd1000;

    // Command kinds
    localparam logic [KIND_W-1:0] K_ON     = 3'd0;
    localparam logic [KIND_W-1:0] K_OFF    = 3'd1;
    localparam logic [KIND_W-1:0] K_TOGGLE = 3'd2;
    localparam logic [KIND_W-1:0] K_PULSE  = 3'd3;
    localparam logic [KIND_W-1:0] K_TICK   = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_GROUP   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PULSING = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_MAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUPS_EN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_W   = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the incoming word
        logic exec;   // apply the held item and load the result register
    } t_cmd;

    typedef logic [NUM_RELAYS-1:0] t_relay_vec;

    // Group number of relay i; map bits above the register read as zero
    function automatic logic [GROUP_BITS-1:0] group_of(input logic [MAP_W-1:0] map,
                                                       input int i);
        logic [GMAP_W+MAP_W-1:0] ext;
        ext = {{GMAP_W{1'b0}}, map};
        return ext[i*GROUP_BITS +: GROUP_BITS];
    endfunction

endpackage

// ----- rtl/grip_ctrl.sv -----
// Handshake controller of the relay bank driver.
`include "assert_macros.svh"

module grip_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output grip_pkg::t_cmd  o_cmd
);
    import grip_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Commands: take a word when idle, execute once the result slot is free
    assign o_s_tready = (r_state == S_IDLE);
    assign o_cmd.load = i_s_tvalid && (r_state == S_IDLE);
    assign o_cmd.exec = (r_state == S_EXEC) && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;

    // Next state and result-valid flag
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.exec) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `ASSERT_NEXT(a_load_to_exec, i_clk, i_rst_n, o_cmd.load, r_state == S_EXEC)
    `ASSERT_NEXT(a_exec_gives_result, i_clk, i_rst_n, o_cmd.exec, o_m_tvalid)
    `ASSERT_NEXT(a_wait_holds, i_clk, i_rst_n, (r_state == S_EXEC) && !o_cmd.exec,
                 (r_state == S_EXEC) && o_m_tvalid)
    `ASSERT_SAME(a_no_take_while_busy, i_clk, i_rst_n, r_state == S_EXEC, !o_s_tready)

endmodule

// ----- rtl/grip_dp.sv -----
// Datapath of the relay bank driver: configuration, relay state and result register.
module grip_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  grip_pkg::t_cmd                       i_cmd,
    input  logic [grip_pkg::KIND_W-1:0]          i_kind,
    input  logic [grip_pkg::RELAY_W-1:0]         i_relay,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [grip_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [grip_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic [grip_pkg::STATES_W-1:0]        o_relay_states,
    output logic [grip_pkg::STATUS_W-1:0]        o_status
);
    import grip_pkg::*;

    // Configuration registers
    logic [MAP_W-1:0] r_group_map;
    logic             r_groups_en;
    logic [EL_W-1:0]  r_pulse_w;

    // Held item
    logic [KIND_W-1:0]  r_kind;
    logic [RELAY_W-1:0] r_relay;

    // Relay state
    t_relay_vec      r_on, n_on;
    t_relay_vec      r_pul, n_pul;
    logic [EL_W-1:0] r_el [NUM_RELAYS];
    logic [EL_W-1:0] n_el [NUM_RELAYS];

    // Result register
    logic [STATES_W-1:0] r_out_states;
    logic [STATUS_W-1:0] r_out_status;

    logic [STATUS_W-1:0]     n_status;
    logic [IDX_W-1:0]        idx;
    logic                    idx_bad;
    logic                    busy;
    t_relay_vec              same_group;
    logic [EL_W-1:0]         inc [NUM_RELAYS];
    logic [NUM_RELAYS+STATES_W-1:0] states_ext;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_map <= '0;
            r_groups_en <= 1'b0;
            r_pulse_w   <= PULSE_WIDTH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GROUP_MAP: r_group_map <= i_cfg_data[MAP_W-1:0];
                CFG_GROUPS_EN: r_groups_en <= i_cfg_data[0];
                CFG_PULSE_W:   r_pulse_w   <= i_cfg_data[EL_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_relay <= i_relay;
        end
    end

    // Interlock check: any on relay sharing the addressed relay's group
    assign idx     = r_relay[IDX_W-1:0];
    assign idx_bad = (r_relay >= RELAY_W'(NUM_RELAYS));

    always_comb begin
        for (int i = 0; i < NUM_RELAYS; i++) begin
            same_group[i] = (group_of(r_group_map, i) == group_of(r_group_map, int'(idx)));
        end
    end

    assign busy = r_groups_en && |(r_on & same_group);

    // Saturating tick counts
    always_comb begin
        for (int i = 0; i < NUM_RELAYS; i++) begin
            inc[i] = (r_el[i] == '1) ? r_el[i] : r_el[i] + EL_W'(1);
        end
    end

    // Apply one item
    always_comb begin
        n_on     = r_on;
        n_pul    = r_pul;
        n_el     = r_el;
        n_status = ST_DONE;
        case (r_kind) inside
            K_TICK: begin
                for (int i = 0; i < NUM_RELAYS; i++) begin
                    if (r_pul[i]) begin
                        n_el[i] = inc[i];
                        if (inc[i] >= r_pulse_w) begin
                            n_on[i]  = 1'b0;
                            n_pul[i] = 1'b0;
                        end
                    end
                end
            end
            K_ON, K_OFF, K_TOGGLE, K_PULSE: begin
                if (idx_bad) begin
                    n_status = ST_BAD_IDX;
                end else begin
                    case (r_kind)
                        K_ON: begin
                            if (busy) n_status = ST_GROUP;
                            else      n_on[idx] = 1'b1;
                        end
                        K_OFF: begin
                            n_on[idx] = 1'b0;
                        end
                        K_TOGGLE: begin
                            if (r_on[idx]) n_on[idx] = 1'b0;
                            else if (busy) n_status  = ST_GROUP;
                            else           n_on[idx] = 1'b1;
                        end
                        default: begin
                            // pulse: marked even when the interlock refuses
                            if (r_pul[idx]) begin
                                n_status = ST_PULSING;
                            end else begin
                                n_pul[idx] = 1'b1;
                                n_el[idx]  = '0;
                                if (busy) n_status  = ST_GROUP;
                                else      n_on[idx] = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on  <= '0;
            r_pul <= '0;
            for (int i = 0; i < NUM_RELAYS; i++) begin
                r_el[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            r_on  <= n_on;
            r_pul <= n_pul;
            r_el  <= n_el;
        end
    end

    // Result word
    assign states_ext = {{STATES_W{1'b0}}, n_on};

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_states <= states_ext[STATES_W-1:0];
            r_out_status <= n_status;
        end
    end

    assign o_relay_states = r_out_states;
    assign o_status       = r_out_status;

endmodule

// ----- rtl/grouped_relay_interlock_pulser.sv -----
// Top level of the relay bank driver with interlock groups and timed pulses.
//
// Input stream (s_axis): tuser carries the command kind (switch on, off,
// toggle, pulse, tick), tdata the relay index. Each word gives exactly one
// result word on the output stream (m_axis): relay on bitmap and status.
// Configuration port: index 0 group map, 1 group enable, 2 pulse width;
// always ready, write only while no command is in flight.
//
// Timing: an accepted word is held in the capture register and applied in the
// execute step, where its result is loaded into the output register. The
// controller sequences capture then execute, so the block takes no new word
// until the held word has been executed; the result is valid from that execute edge on.
// A new word may be accepted while the previous result still waits.
// When the receiver stalls, the held result stays put and the next word
// waits in the capture register until the result slot frees.
// Reset (synchronous, active low): all relays off, no pulses, counts zero,
// group map zero, groups disabled, pulse width 1000 ticks.
module grouped_relay_interlock_pulser (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // s_axis_tdata: [7:0] relay
    input  logic [grip_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    // s_axis_tuser: [2:0] kind
    input  logic [grip_pkg::IN_TUSER_W-1:0]       i_s_tuser,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // m_axis_tdata: [7:0] relay_states, [9:8] status, [15:10] zero
    output logic [grip_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [grip_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [grip_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import grip_pkg::*;

    t_cmd                cmd;
    logic [STATES_W-1:0] relay_states;
    logic [STATUS_W-1:0] status;

    grip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    grip_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (i_s_tuser[KIND_W-1:0]),
        .i_relay        (i_s_tdata[RELAY_W-1:0]),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_relay_states (relay_states),
        .o_status       (status)
    );

    // Pack the result word
    assign o_m_tdata = {{(OUT_TDATA_W-STATES_W-STATUS_W){1'b0}}, status, relay_states};

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the relay bank driver with interlock groups and pulses.
`timescale 1ns / 1ps

module tb;
    import grip_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int NUM_PHASES    = 8;
    localparam int CMDS_PER_PHASE = 173;
    localparam int SETTLE_CYCLES = 8;

    // Kinds that the block ignores
    localparam logic [KIND_W-1:0] K_SPARE_A = 3'd5;
    localparam logic [KIND_W-1:0] K_SPARE_C = 3'd7;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [RELAY_W-1:0] relay;
    } t_relay_cmd;

    typedef struct {
        t_relay_cmd          cmd;
        logic [STATES_W-1:0] states;
        logic [STATUS_W-1:0] status;
    } t_relay_result;

    logic                         i_clk;
    logic                         i_rst_n;
    logic [IN_TDATA_W-1:0]        i_s_tdata;
    logic [IN_TUSER_W-1:0]        i_s_tuser;
    logic                         i_s_tvalid;
    logic                         o_s_tready;
    logic [OUT_TDATA_W-1:0]       o_m_tdata;
    logic                         o_m_tvalid;
    logic                         i_m_tready;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CFG_DATA_W-1:0]        i_cfg_data;

    // Stimulus and expectation stores
    t_relay_cmd    cmd_queue[$];
    t_relay_result relay_result_queue[$];
    t_relay_cmd    next_cmd;
    logic          cmd_taken;

    // Idle percentages of the current phase
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // Predicted bank state and register copies
    logic [NUM_RELAYS-1:0] relay_on_bits;
    logic [NUM_RELAYS-1:0] pulse_mark;
    logic [EL_W-1:0]       pulse_ticks[NUM_RELAYS];
    logic [MAP_W-1:0]      cfg_group_map;
    logic                  cfg_groups_on;
    logic [EL_W-1:0]       cfg_pulse_len;

    // Run statistics
    int error_count;
    int cmds_sent;
    int results_checked;
    int pulse_expiries;
    int refusals;

    grouped_relay_interlock_pulser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Interlock group of relay i as held in the map copy
    function automatic logic [GROUP_BITS-1:0] relay_group(input int i);
        return GROUP_BITS'(cfg_group_map >> (i * GROUP_BITS));
    endfunction

    // True when groups are enabled and some relay of r's group (r included) is already on
    function automatic logic interlock_blocked(input int r);
        if (!cfg_groups_on)
            return 1'b0;
        for (int i = 0; i < NUM_RELAYS; i++)
            if (relay_on_bits[i] && relay_group(i) == relay_group(r))
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [STATUS_W-1:0] switch_relay(input int r, input logic turn_on);
        if (turn_on && interlock_blocked(r))
            return ST_GROUP;
        relay_on_bits[r] = turn_on;
        return ST_DONE;
    endfunction

    // Apply one command to the predicted bank and return its result word
    function automatic t_relay_result apply_relay_cmd(input t_relay_cmd cmd);
        t_relay_result res;
        int r;
        res.cmd = cmd;
        res.status = ST_DONE;
        r = cmd.relay;
        if (cmd.kind == K_TICK) begin
            for (int i = 0; i < NUM_RELAYS; i++) begin
                if (pulse_mark[i]) begin
                    if (pulse_ticks[i] != '1)
                        pulse_ticks[i] = pulse_ticks[i] + EL_W'(1);
                    if (pulse_ticks[i] >= cfg_pulse_len) begin
                        relay_on_bits[i] = 1'b0;
                        pulse_mark[i] = 1'b0;
                        pulse_expiries++;
                    end
                end
            end
        end else if (cmd.kind <= K_PULSE) begin
            if (r >= NUM_RELAYS) begin
                res.status = ST_BAD_IDX;
            end else begin
                case (cmd.kind)
                    K_ON:     res.status = switch_relay(r, 1'b1);
                    K_OFF:    res.status = switch_relay(r, 1'b0);
                    K_TOGGLE: res.status = switch_relay(r, !relay_on_bits[r]);
                    default: begin
                        if (pulse_mark[r]) begin
                            res.status = ST_PULSING;
                        end else begin
                            // a refused pulse still marks the relay and clears its count
                            pulse_mark[r] = 1'b1;
                            pulse_ticks[r] = '0;
                            res.status = switch_relay(r, 1'b1);
                        end
                    end
                endcase
            end
        end
        if (res.status == ST_GROUP)
            refusals++;
        res.states = relay_on_bits;
        return res;
    endfunction

    function automatic logic send_gap();
        return $urandom_range(99) < send_idle_pct;
    endfunction

    // Stream driver: new word or idle at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_tvalid || cmd_taken) begin
                if (cmd_queue.size() > 0 && !send_gap()) begin
                    next_cmd = cmd_queue.pop_front();
                    i_s_tuser  <= next_cmd.kind;
                    i_s_tdata  <= next_cmd.relay;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= !($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: predict accepted words, check result words
    always @(posedge i_clk) begin
        t_relay_result want;
        cmd_taken = 1'b0;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                cmd_taken = 1'b1;
                next_cmd.kind  = i_s_tuser;
                next_cmd.relay = i_s_tdata;
                relay_result_queue.push_back(apply_relay_cmd(next_cmd));
                cmds_sent++;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (relay_result_queue.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("ERROR: result word %h with nothing expected", o_m_tdata);
                end else begin
                    want = relay_result_queue.pop_front();
                    results_checked++;
                    if (o_m_tdata[STATES_W-1:0] !== want.states ||
                        o_m_tdata[STATES_W+STATUS_W-1:STATES_W] !== want.status) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("ERROR: kind %0d relay %0d: states %b status %0d, got %b %0d",
                                     want.cmd.kind, want.cmd.relay, want.states, want.status,
                                     o_m_tdata[STATES_W-1:0],
                                     o_m_tdata[STATES_W+STATUS_W-1:STATES_W]);
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("grouped_relay_interlock_pulser test failed");
        $finish;
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_GROUP_MAP: cfg_group_map = val[MAP_W-1:0];
            CFG_GROUPS_EN: cfg_groups_on = val[0];
            default:       cfg_pulse_len = val[EL_W-1:0];
        endcase
    endtask

    // Write all three registers; only called while the bank is idle
    task automatic load_config(input logic [MAP_W-1:0] map, input logic en,
                               input logic [EL_W-1:0] width);
        cfg_write(CFG_GROUP_MAP, map);
        cfg_write(CFG_GROUPS_EN, CFG_DATA_W'(en));
        cfg_write(CFG_PULSE_W, CFG_DATA_W'(width));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_cmd(input logic [KIND_W-1:0] kind, input logic [RELAY_W-1:0] relay);
        t_relay_cmd c;
        c.kind = kind;
        c.relay = relay;
        cmd_queue.push_back(c);
    endtask

    // Wait until every word is sent and answered, then let the pipeline settle
    task automatic drain();
        while (cmd_queue.size() != 0 || i_s_tvalid || relay_result_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random command mix: mostly valid relays, with ticks often enough for pulses to end
    task automatic push_random_cmd(output logic counted);
        int unsigned w;
        logic [RELAY_W-1:0] valid_relay;
        w = $urandom_range(99);
        valid_relay = RELAY_W'($urandom_range(NUM_RELAYS - 1));
        counted = 1'b1;
        if (w < 35)
            push_cmd(K_TICK, RELAY_W'($urandom_range(255)));
        else if (w < 52)
            push_cmd(K_PULSE, valid_relay);
        else if (w < 67)
            push_cmd(K_ON, valid_relay);
        else if (w < 77)
            push_cmd(K_OFF, valid_relay);
        else if (w < 89)
            push_cmd(K_TOGGLE, valid_relay);
        else if (w < 97)
            push_cmd(KIND_W'($urandom_range(K_PULSE)),
                     RELAY_W'($urandom_range(255, NUM_RELAYS)));
        else begin
            push_cmd(KIND_W'($urandom_range(K_SPARE_C, K_SPARE_A)),
                     RELAY_W'($urandom_range(255)));
            counted = 1'b0;
        end
    endtask

    // Main sequence
    initial begin : main_seq
        logic [MAP_W-1:0] map;
        logic             en;
        logic [EL_W-1:0]  width;
        logic             counted;
        int               n;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_m_tready  = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        cmd_taken   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count = 0;
        cmds_sent = 0;
        results_checked = 0;
        pulse_expiries = 0;
        refusals = 0;

        // Reset state of the predicted bank
        relay_on_bits = '0;
        pulse_mark    = '0;
        for (int i = 0; i < NUM_RELAYS; i++)
            pulse_ticks[i] = '0;
        cfg_group_map = '0;
        cfg_groups_on = 1'b0;
        cfg_pulse_len = PULSE_WIDTH_RST;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: relays 0,1 share group 0, 2,3 group 1, the rest own groups
        load_config({3'd7, 3'd6, 3'd5, 3'd4, 3'd1, 3'd1, 3'd0, 3'd0}, 1'b1, 16'd1);
        push_cmd(K_ON, 8'd0);       // done
        push_cmd(K_ON, 8'd0);       // refused, sees itself on
        push_cmd(K_ON, 8'd1);       // refused by group partner
        push_cmd(K_OFF, 8'd1);      // switch off is never refused
        push_cmd(K_TOGGLE, 8'd0);   // on to off
        push_cmd(K_TOGGLE, 8'd1);   // off to on
        push_cmd(K_TOGGLE, 8'd0);   // refused
        push_cmd(K_PULSE, 8'd2);    // pulse starts
        push_cmd(K_PULSE, 8'd2);    // already pulsing
        push_cmd(K_PULSE, 8'd3);    // refused but marked pulsing
        push_cmd(K_TICK, 8'd255);   // both pulses end
        push_cmd(K_PULSE, 8'd3);    // may pulse again
        push_cmd(K_ON, 8'd8);       // invalid relays
        push_cmd(K_OFF, 8'd255);
        push_cmd(K_TOGGLE, 8'd128);
        push_cmd(K_PULSE, 8'd247);
        push_cmd(K_SPARE_A, 8'd0);  // ignored kinds
        push_cmd(K_SPARE_A + 3'd1, 8'd7);
        push_cmd(K_SPARE_C, 8'd255);
        push_cmd(K_ON, 8'd7);
        push_cmd(K_ON, 8'd6);
        push_cmd(K_TICK, 8'd0);
        push_cmd(K_OFF, 8'd7);
        drain();

        // Random phases across register settings and idle patterns
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            map = MAP_W'($urandom());
            en = 1'b1;
            case (ph)
                0: width = 16'd0;
                1: begin map = '0; width = 16'd1; end
                2: begin map = '1; width = 16'd3; end
                3: begin en = 1'b0; width = 16'd5; end
                4: width = 16'hFFFF;
                5: width = 16'd2;
                6: begin en = 1'b0; width = EL_W'($urandom_range(8)); end
                default: width = EL_W'($urandom_range(8));
            endcase
            load_config(map, en, width);
            n = 0;
            while (n < CMDS_PER_PHASE) begin
                push_random_cmd(counted);
                if (counted)
                    n++;
            end
            drain();
        end

        error_count += relay_result_queue.size();
        $display("Sent %0d commands over %0d register settings, %0d results checked",
                 cmds_sent, NUM_PHASES + 1, results_checked);
        $display("Saw %0d pulse expiries and %0d interlock refusals", pulse_expiries, refusals);
        if (error_count == 0) begin
            $display("grouped_relay_interlock_pulser test passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("grouped_relay_interlock_pulser test failed");
        end
        $finish;
    end

endmodule
